/* rtl/qjesc_pkg.sv */
// shared types, widths and the micro-program decode for the quaternion julia iterator
// used by qjesc_mac and quaternion_julia_escape_iterate; depends on nothing
package qjesc_pkg;

    // default fixed-point formats
    localparam int Q_FRAC_DEF = 26;
    localparam int D_FRAC_DEF = 24;

    // field widths
    localparam int Q_W       = 32;
    localparam int D_W       = 48;
    localparam int CNT_W     = 8;
    localparam int LIM_W     = 38;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 38;

    // datapath widths: d is multiplied in two halves, b operand is one bit wider than q
    localparam int D_SPLIT = D_W / 2;
    localparam int OPB_W   = Q_W + 1;
    localparam int PROD_W  = Q_W + OPB_W;
    localparam int ACC_W   = 84;

    // micro-program layout of one iteration
    localparam int OP_W       = 6;
    localparam int OP_Q0_C    = 4;
    localparam int OP_QX_BASE = 5;
    localparam int OP_D_BASE  = 11;
    localparam int OP_N_BASE  = 43;
    localparam int N_OPS      = 47;
    localparam int OP_LAST    = N_OPS - 1;

    typedef logic [1:0] t_asrc;
    localparam t_asrc A_QOLD = 2'd0;
    localparam t_asrc A_QNEW = 2'd1;
    localparam t_asrc A_CON  = 2'd2;

    typedef logic [2:0] t_bsrc;
    localparam t_bsrc B_QOLD = 3'd0;
    localparam t_bsrc B_QNEW = 3'd1;
    localparam t_bsrc B_DHI  = 3'd2;
    localparam t_bsrc B_DLO  = 3'd3;
    localparam t_bsrc B_ONE  = 3'd4;

    typedef logic [1:0] t_shift;
    localparam t_shift SH_NONE = 2'd0;
    localparam t_shift SH_DBL  = 2'd1;
    localparam t_shift SH_HALF = 2'd2;

    typedef logic [1:0] t_dest;
    localparam t_dest DST_QN   = 2'd0;
    localparam t_dest DST_DN   = 2'd1;
    localparam t_dest DST_NORM = 2'd2;

    // control that travels with a product through the mac
    typedef struct packed {
        logic       valid;
        logic       neg;
        t_shift     sh;
        logic       first;
        logic       last;
        t_dest      dest;
        logic [1:0] dest_idx;
    } t_mac_ctl;

    // completed sum announcement from the mac
    typedef struct packed {
        logic       valid;
        t_dest      dest;
        logic [1:0] idx;
    } t_fin;

    typedef struct packed {
        t_mac_ctl   ctl;
        t_asrc      a_src;
        logic [1:0] a_idx;
        t_bsrc      b_src;
        logic [1:0] b_idx;
    } t_uop;

    typedef struct packed {
        logic [1:0] a;
        logic [1:0] b;
        logic       neg;
    } t_ham;

    // hamilton product term: component c, term t -> x[a] * y[b] with sign
    function automatic t_ham ham_term(input logic [3:0] ct);
        t_ham h;
        case (ct)
            4'h0: h = '{a: 2'd0, b: 2'd0, neg: 1'b0};
            4'h1: h = '{a: 2'd1, b: 2'd1, neg: 1'b1};
            4'h2: h = '{a: 2'd2, b: 2'd2, neg: 1'b1};
            4'h3: h = '{a: 2'd3, b: 2'd3, neg: 1'b1};
            4'h4: h = '{a: 2'd0, b: 2'd1, neg: 1'b0};
            4'h5: h = '{a: 2'd1, b: 2'd0, neg: 1'b0};
            4'h6: h = '{a: 2'd2, b: 2'd3, neg: 1'b0};
            4'h7: h = '{a: 2'd3, b: 2'd2, neg: 1'b1};
            4'h8: h = '{a: 2'd0, b: 2'd2, neg: 1'b0};
            4'h9: h = '{a: 2'd1, b: 2'd3, neg: 1'b1};
            4'ha: h = '{a: 2'd2, b: 2'd0, neg: 1'b0};
            4'hb: h = '{a: 2'd3, b: 2'd1, neg: 1'b0};
            4'hc: h = '{a: 2'd0, b: 2'd3, neg: 1'b0};
            4'hd: h = '{a: 2'd1, b: 2'd2, neg: 1'b0};
            4'he: h = '{a: 2'd2, b: 2'd1, neg: 1'b1};
            4'hf: h = '{a: 2'd3, b: 2'd0, neg: 1'b0};
            default: h = '0;
        endcase
        return h;
    endfunction

    // one micro-op of the iteration program
    // q*q first (real part as four squares, the others as doubled cross terms,
    // each closed by c times one), then d*q in halves, then |q_new|^2
    function automatic t_uop qjesc_decode(input logic [OP_W-1:0] op);
        t_uop            u;
        logic [OP_W-1:0] k;
        t_ham            h;
        u = '0;
        k = '0;
        h = '0;
        if (op < OP_W'(OP_QX_BASE)) begin
            u.ctl.dest     = DST_QN;
            u.ctl.dest_idx = 2'd0;
            if (op == OP_W'(OP_Q0_C)) begin
                u.a_src    = A_CON;
                u.b_src    = B_ONE;
                u.ctl.last = 1'b1;
            end else begin
                u.a_src     = A_QOLD;
                u.a_idx     = op[1:0];
                u.b_src     = B_QOLD;
                u.b_idx     = op[1:0];
                u.ctl.neg   = (op != '0);
                u.ctl.first = (op == '0);
            end
        end else if (op < OP_W'(OP_D_BASE)) begin
            k              = op - OP_W'(OP_QX_BASE);
            u.ctl.dest     = DST_QN;
            u.ctl.dest_idx = k[2:1] + 2'd1;
            if (!k[0]) begin
                u.a_src     = A_QOLD;
                u.a_idx     = 2'd0;
                u.b_src     = B_QOLD;
                u.b_idx     = k[2:1] + 2'd1;
                u.ctl.sh    = SH_DBL;
                u.ctl.first = 1'b1;
            end else begin
                u.a_src    = A_CON;
                u.a_idx    = k[2:1] + 2'd1;
                u.b_src    = B_ONE;
                u.ctl.last = 1'b1;
            end
        end else if (op < OP_W'(OP_N_BASE)) begin
            k              = op - OP_W'(OP_D_BASE);
            h              = ham_term(k[4:1]);
            u.a_src        = A_QOLD;
            u.a_idx        = h.b;
            u.b_src        = k[0] ? B_DHI : B_DLO;
            u.b_idx        = h.a;
            u.ctl.sh       = k[0] ? SH_HALF : SH_NONE;
            u.ctl.neg      = h.neg;
            u.ctl.first    = (k[2:0] == 3'd0);
            u.ctl.last     = &k[2:0];
            u.ctl.dest     = DST_DN;
            u.ctl.dest_idx = k[4:3];
        end else begin
            k              = op - OP_W'(OP_N_BASE);
            u.a_src        = A_QNEW;
            u.a_idx        = k[1:0];
            u.b_src        = B_QNEW;
            u.b_idx        = k[1:0];
            u.ctl.first    = (k[1:0] == 2'd0);
            u.ctl.last     = &k[1:0];
            u.ctl.dest     = DST_NORM;
            u.ctl.dest_idx = 2'd0;
        end
        return u;
    endfunction

endpackage

/* rtl/qjesc_mac.sv */
// shared signed multiply-accumulate unit: registered product, then signed accumulate
// depends on qjesc_pkg
module qjesc_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  qjesc_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [qjesc_pkg::Q_W-1:0]      i_opa,
    input  logic signed [qjesc_pkg::OPB_W-1:0]    i_opb,
    output qjesc_pkg::t_fin                       o_fin,
    output logic signed [qjesc_pkg::ACC_W-1:0]    o_acc
);
    import qjesc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    t_mac_ctl                 r_pctl;
    logic signed [ACC_W-1:0]  r_acc;
    t_fin                     r_fin;

    logic signed [ACC_W-1:0]  ext;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  n_acc;

    always_comb begin
        ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        case (r_pctl.sh)
            SH_DBL:  term = ext <<< 1;
            SH_HALF: term = ext <<< D_SPLIT;
            default: term = ext;
        endcase
        base  = r_pctl.first ? '0 : r_acc;
        n_acc = r_pctl.neg ? (base - term) : (base + term);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_opa) * PROD_W'(i_opb);
        if (r_pctl.valid) begin
            r_acc <= n_acc;
        end
        r_fin.dest <= r_pctl.dest;
        r_fin.idx  <= r_pctl.dest_idx;
        if (!i_rst_n) begin
            r_pctl    <= '0;
            r_fin.valid <= 1'b0;
        end else begin
            r_pctl      <= i_ctl;
            r_fin.valid <= r_pctl.valid & r_pctl.last;
        end
    end

    assign o_fin = r_fin;
    assign o_acc = r_acc;

endmodule

/* rtl/quaternion_julia_escape_iterate.sv */
// quaternion julia escape-time iterator with running derivative, top level
// sequencer, operand selection, rounding/saturation and handshakes; uses qjesc_pkg, qjesc_mac
//
//  channel   direction  handshake                      payload
//  input     in         i_in_valid / o_in_stall        i_point_x, i_point_y, i_point_z
//  result    out        o_out_valid / i_out_stall      o_escape_count, o_final_*, o_deriv_*,
//                                                      o_overflow_flag
//  config    in         i_cfg_wr_en                    i_cfg_idx, i_cfg_wdata
//
// one iteration issues 47 products to the single 32x33 multiplier (11 for q*q + c,
// 32 for d*q in two halves of d, 4 for |q|^2), then waits while the last sums drain through the
// operand, product and accumulator registers before the norm decides on escape
// the input stalls from accept until the result is parked in the output register;
// a parked result waiting on i_out_stall does not block the next item, only its finish
// synchronous active-low reset clears control and loads the register defaults
module quaternion_julia_escape_iterate #(
    parameter int Q_FRAC_BITS = qjesc_pkg::Q_FRAC_DEF,
    parameter int D_FRAC_BITS = qjesc_pkg::D_FRAC_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // configuration writes
    input  logic                                       i_cfg_wr_en,
    input  logic [qjesc_pkg::CFG_IDX_W-1:0]            i_cfg_idx,
    input  logic [qjesc_pkg::CFG_W-1:0]                i_cfg_wdata,
    // input items
    input  logic                                       i_in_valid,
    output logic                                       o_in_stall,
    input  logic signed [qjesc_pkg::Q_W-1:0]           i_point_x,
    input  logic signed [qjesc_pkg::Q_W-1:0]           i_point_y,
    input  logic signed [qjesc_pkg::Q_W-1:0]           i_point_z,
    // result items
    output logic                                       o_out_valid,
    input  logic                                       i_out_stall,
    output logic [qjesc_pkg::CNT_W-1:0]                o_escape_count,
    output logic signed [qjesc_pkg::Q_W-1:0]           o_final_real,
    output logic signed [qjesc_pkg::Q_W-1:0]           o_final_i,
    output logic signed [qjesc_pkg::Q_W-1:0]           o_final_j,
    output logic signed [qjesc_pkg::Q_W-1:0]           o_final_k,
    output logic signed [qjesc_pkg::D_W-1:0]           o_deriv_real,
    output logic signed [qjesc_pkg::D_W-1:0]           o_deriv_i,
    output logic signed [qjesc_pkg::D_W-1:0]           o_deriv_j,
    output logic signed [qjesc_pkg::D_W-1:0]           o_deriv_k,
    output logic                                       o_overflow_flag
);
    import qjesc_pkg::*;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_C_REAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_C_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_C_J     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_C_K     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 3'd5;

    localparam logic [CNT_W-1:0] MAX_IT_RST = 8'd64;
    localparam logic [LIM_W-1:0] LIMIT_RST  = 38'd1073741824;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic signed [Q_W-1:0]   Q_MAX  = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0]   Q_MIN  = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [D_W-1:0]   D_MAX  = {1'b0, {(D_W-1){1'b1}}};
    localparam logic signed [D_W-1:0]   D_MIN  = {1'b1, {(D_W-1){1'b0}}};
    localparam logic signed [D_W-1:0]   D_ONE  = D_W'(1) << D_FRAC_BITS;
    localparam logic signed [OPB_W-1:0] Q_UNIT = OPB_W'(1) << Q_FRAC_BITS;

    // configuration registers
    logic signed [Q_W-1:0] r_c [4];
    logic [CNT_W-1:0]      r_max_it;
    logic [LIM_W-1:0]      r_lim;

    // iteration state: current and next q, d
    logic signed [Q_W-1:0] r_q  [4];
    logic signed [Q_W-1:0] r_qn [4];
    logic signed [D_W-1:0] r_d  [4];
    logic signed [D_W-1:0] r_dn [4];
    logic                  r_ov;
    logic [CNT_W-1:0]      r_iter;
    logic [CNT_W-1:0]      r_count;
    logic [OP_W-1:0]       r_op;
    logic [1:0]            r_state;

    // registered operands feeding the multiplier
    t_mac_ctl                r_ctl;
    logic signed [Q_W-1:0]   r_opa;
    logic signed [OPB_W-1:0] r_opb;

    // output register
    logic                  r_out_valid;
    logic [CNT_W-1:0]      r_out_count;
    logic signed [Q_W-1:0] r_out_q [4];
    logic signed [D_W-1:0] r_out_d [4];
    logic                  r_out_ov;

    t_uop                    uop;
    logic signed [Q_W-1:0]   n_opa;
    logic signed [OPB_W-1:0] n_opb;
    t_fin                    fin;
    logic signed [ACC_W-1:0] acc;

    logic signed [ACC_W-1:0] sh_q;
    logic signed [ACC_W-1:0] sh_d;
    logic                    q_fit;
    logic                    d_fit;
    logic signed [Q_W-1:0]   q_sat;
    logic signed [D_W-1:0]   d_sat;
    logic [ACC_W-1:0]        lim_full;
    logic                    escaped;
    logic                    in_acc;
    logic                    out_take;
    logic                    norm_done;

    assign in_acc    = i_in_valid & ~o_in_stall;
    assign out_take  = r_out_valid & ~i_out_stall;
    assign norm_done = fin.valid & (fin.dest == DST_NORM);

    // operand selection for the current micro-op
    always_comb begin
        uop = qjesc_decode(r_op);
        uop.ctl.valid = (r_state == S_RUN);
        case (uop.a_src)
            A_QOLD:  n_opa = r_q[uop.a_idx];
            A_QNEW:  n_opa = r_qn[uop.a_idx];
            A_CON:   n_opa = r_c[uop.a_idx];
            default: n_opa = '0;
        endcase
        case (uop.b_src)
            B_QOLD:  n_opb = OPB_W'(r_q[uop.b_idx]);
            B_QNEW:  n_opb = OPB_W'(r_qn[uop.b_idx]);
            // upper half of d is signed, lower half is a plain magnitude
            B_DHI:   n_opb = OPB_W'($signed(r_d[uop.b_idx][D_W-1:D_SPLIT]));
            B_DLO:   n_opb = {{(OPB_W-D_SPLIT){1'b0}}, r_d[uop.b_idx][D_SPLIT-1:0]};
            B_ONE:   n_opb = Q_UNIT;
            default: n_opb = '0;
        endcase
    end

    qjesc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl),
        .i_opa   (r_opa),
        .i_opb   (r_opb),
        .o_fin   (fin),
        .o_acc   (acc)
    );

    // floor shifts and saturation of a finished sum; the d shift folds in the factor 2
    always_comb begin
        sh_q  = acc >>> Q_FRAC_BITS;
        sh_d  = acc >>> (Q_FRAC_BITS - 1);
        q_fit = (&sh_q[ACC_W-1:Q_W-1]) | ~(|sh_q[ACC_W-1:Q_W-1]);
        d_fit = (&sh_d[ACC_W-1:D_W-1]) | ~(|sh_d[ACC_W-1:D_W-1]);
        q_sat = q_fit ? sh_q[Q_W-1:0] : (sh_q[ACC_W-1] ? Q_MIN : Q_MAX);
        d_sat = d_fit ? sh_d[D_W-1:0] : (sh_d[ACC_W-1] ? D_MIN : D_MAX);
        // squared limit scaled to the product format; |q|^2 is never negative
        lim_full = ACC_W'(r_lim) << Q_FRAC_BITS;
        escaped  = $unsigned(acc) > lim_full;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c[0]   <= '0;
            r_c[1]   <= '0;
            r_c[2]   <= '0;
            r_c[3]   <= '0;
            r_max_it <= MAX_IT_RST;
            r_lim    <= LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_C_REAL: r_c[0]   <= i_cfg_wdata[Q_W-1:0];
                CFG_C_I:    r_c[1]   <= i_cfg_wdata[Q_W-1:0];
                CFG_C_J:    r_c[2]   <= i_cfg_wdata[Q_W-1:0];
                CFG_C_K:    r_c[3]   <= i_cfg_wdata[Q_W-1:0];
                CFG_MAX_IT: r_max_it <= i_cfg_wdata[CNT_W-1:0];
                CFG_LIMIT:  r_lim    <= i_cfg_wdata[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // operand stage
    always_ff @(posedge i_clk) begin
        r_opa <= n_opa;
        r_opb <= n_opb;
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= uop.ctl;
        end
    end

    // finished sums land in the next-state buffers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ov <= 1'b0;
        end else if (fin.valid) begin
            case (fin.dest)
                DST_QN: begin
                    r_qn[fin.idx] <= q_sat;
                    if (!q_fit) begin
                        r_ov <= 1'b1;
                    end
                end
                DST_DN: begin
                    r_dn[fin.idx] <= d_sat;
                    if (!d_fit) begin
                        r_ov <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_q[0]  <= i_point_x;
                        r_q[1]  <= i_point_y;
                        r_q[2]  <= i_point_z;
                        r_q[3]  <= '0;
                        r_d[0]  <= D_ONE;
                        r_d[1]  <= '0;
                        r_d[2]  <= '0;
                        r_d[3]  <= '0;
                        r_iter  <= '0;
                        r_op    <= '0;
                        // no iterations configured: hand back the point as is
                        r_count <= '0;
                        r_state <= (r_max_it == '0) ? S_DONE : S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_op == OP_W'(OP_LAST)) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_op <= r_op + 1'b1;
                    end
                end
                S_WAIT: begin
                    // the norm is the last sum of an iteration: commit and decide
                    if (norm_done) begin
                        r_q <= r_qn;
                        r_d <= r_dn;
                        r_op <= '0;
                        if (escaped) begin
                            r_count <= r_iter;
                            r_state <= S_DONE;
                        end else if (r_iter == r_max_it - 8'd1) begin
                            r_count <= r_max_it;
                            r_state <= S_DONE;
                        end else begin
                            r_iter  <= r_iter + 8'd1;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register, loaded when the previous result has left
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out_count <= r_count;
            r_out_q     <= r_q;
            r_out_d     <= r_d;
            r_out_ov    <= r_ov;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_escape_count  = r_out_count;
    assign o_final_real    = r_out_q[0];
    assign o_final_i       = r_out_q[1];
    assign o_final_j       = r_out_q[2];
    assign o_final_k       = r_out_q[3];
    assign o_deriv_real    = r_out_d[0];
    assign o_deriv_i       = r_out_d[1];
    assign o_deriv_j       = r_out_d[2];
    assign o_deriv_k       = r_out_d[3];
    assign o_overflow_flag = r_out_ov;

endmodule
